[rtl/flconv_pkg.sv]
// Shared types, constants and request codes for the full linear convolution block.
package flconv_pkg;

   // Field widths fixed by the request and result formats.
   localparam int VALUE_W      = 16;
   localparam int PROD_W       = 2 * VALUE_W;
   localparam int SUM_W        = 36;
   localparam int MAX_TAPS_DEF = 16;

   // Request function codes.
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Saturation limits of the result sum.
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // One input request.
   typedef struct packed {
      logic                      func;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } flconv_req_type;

   // One result.
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic                    final_res;
   } flconv_rsp_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;
      logic clear;
      logic tap_we;
      logic active;
   } flconv_cell_ctrl_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAVE,
      ST_HOLD
   } flconv_state_type;

endpackage

[rtl/flconv_cell.sv]
// One convolution cell: a tap, a delay line stage and one step of the running sum.
module flconv_cell
   import flconv_pkg::*;
#(
   parameter int ACC_W = SUM_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  flconv_cell_ctrl_type       ctrl,
   input  logic signed [VALUE_W-1:0]  tap_in,
   input  logic signed [VALUE_W-1:0]  smp_in,
   input  logic                       go_in,
   input  logic signed [ACC_W-1:0]    sum_in,
   output logic signed [VALUE_W-1:0]  smp_out,
   output logic                       go_out,
   output logic signed [ACC_W-1:0]    sum_out
);

   logic signed [VALUE_W-1:0] tap_ff;
   logic signed [VALUE_W-1:0] smp_ff;
   logic signed [VALUE_W-1:0] smp_in_w;
   logic                      go_ff;
   logic signed [ACC_W-1:0]   sum_ff;
   logic signed [ACC_W-1:0]   sum_in_w;
   logic signed [PROD_W-1:0]  prod;
   logic signed [ACC_W-1:0]   term;

   // Product of this cell's tap and sample, dropped when the tap is inactive.
   always_comb begin
      prod = tap_ff * smp_ff;
      term = ctrl.active ? {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod} : '0;
      sum_in_w = sum_in + term;
   end

   // Delay line stage: clear wins over shift.
   always_comb begin
      if (ctrl.clear) begin
         smp_in_w = '0;
      end else if (ctrl.shift) begin
         smp_in_w = smp_in;
      end else begin
         smp_in_w = smp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_ff <= '0;
         go_ff  <= 1'b0;
      end else begin
         smp_ff <= smp_in_w;
         go_ff  <= go_in;
      end
   end

   // Tap store entry and the running sum carry no reset.
   always_ff @(posedge clock) begin
      if (ctrl.tap_we) begin
         tap_ff <= tap_in;
      end
      if (go_in) begin
         sum_ff <= sum_in_w;
      end
   end

   assign smp_out = smp_ff;
   assign go_out  = go_ff;
   assign sum_out = sum_ff;

endmodule

[rtl/full_linear_convolution_top.sv]
// Full linear convolution: a chain of tap cells driven by a small sequencer.
// A tap load request gives no result.
// A sample request launches a running sum down the cell chain; no new request is accepted
// until the sequencer returns to idle after the last result of that sample.
// Each tail result of a final sample starts a new running sum walking the cell chain.
// Reset clears the delay line and tap count.
module full_linear_convolution_top
   import flconv_pkg::*;
#(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  flconv_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output flconv_rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int ACC_W0 = PROD_W + $clog2(MAX_TAPS);
   localparam int ACC_W  = (ACC_W0 > SUM_W) ? ACC_W0 : SUM_W;

   flconv_state_type state_ff, state_in;

   logic [CNT_W-1:0] tap_count_ff, tap_count_in;
   logic [CNT_W-1:0] load_index_ff, load_index_in;
   logic [CNT_W-1:0] tails_ff, tails_in;
   logic [CNT_W-1:0] index_next;
   logic             last_ff, last_in;
   logic             launch_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   flconv_rsp_type   rsp_data_ff;

   logic req_fire, load_fire, smp_fire;
   logic done, slot_free, out_fire, tail_fire, end_fire;
   logic shift, clear;
   logic signed [VALUE_W-1:0] shift_val;
   logic signed [SUM_W-1:0]   sum_sat;

   logic [MAX_TAPS-1:0]        go_vec;
   logic signed [VALUE_W-1:0]  smp_vec [MAX_TAPS];
   logic signed [ACC_W-1:0]    sum_vec [MAX_TAPS];

   // Handshake decode.
   assign req_fire  = req_valid && req_ready;
   assign load_fire = req_fire && (req_data.func == FUNC_LOAD);
   assign smp_fire  = req_fire && (req_data.func == FUNC_SAMPLE);
   assign done      = go_vec[MAX_TAPS-1];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (smp_fire) begin
               state_in = ST_WAVE;
            end
         end
         ST_WAVE: begin
            if (done) begin
               if (!slot_free) begin
                  state_in = ST_HOLD;
               end else if (tails_ff != '0) begin
                  state_in = ST_WAVE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = (tails_ff != '0) ? ST_WAVE : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      out_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_WAVE: out_fire  = done && slot_free;
         ST_HOLD: out_fire  = slot_free;
         default: req_ready = 1'b0;
      endcase
   end

   // A result with tails left pushes a zero and starts the next sum.
   assign tail_fire = out_fire && (tails_ff != '0);
   assign end_fire  = out_fire && (tails_ff == '0) && last_ff;
   assign shift     = smp_fire || tail_fire;
   assign shift_val = smp_fire ? req_data.value : '0;
   assign clear     = (load_fire && req_data.last) || end_fire;

   // Tap loading and tap count.
   always_comb begin
      index_next    = (load_index_ff < CNT_W'(MAX_TAPS)) ? load_index_ff + 1'b1
                                                         : load_index_ff;
      load_index_in = load_index_ff;
      tap_count_in  = tap_count_ff;
      if (load_fire) begin
         if (req_data.last) begin
            load_index_in = '0;
            tap_count_in  = index_next;
         end else begin
            load_index_in = index_next;
         end
      end
   end

   // Tail count and final flag of the current sample.
   always_comb begin
      tails_in = tails_ff;
      last_in  = last_ff;
      if (smp_fire) begin
         last_in  = req_data.last;
         tails_in = (req_data.last && (tap_count_ff > CNT_W'(1))) ? tap_count_ff - 1'b1
                                                                 : '0;
      end else if (tail_fire) begin
         tails_in = tails_ff - 1'b1;
      end
   end

   // Saturate the accumulated sum to the result width.
   generate
      if (ACC_W > SUM_W) begin : g_sat
         logic [ACC_W-SUM_W:0] hi;
         assign hi      = sum_vec[MAX_TAPS-1][ACC_W-1:SUM_W-1];
         assign sum_sat = ((&hi) || !(|hi)) ? sum_vec[MAX_TAPS-1][SUM_W-1:0]
                        : (hi[ACC_W-SUM_W] ? SUM_MIN : SUM_MAX);
      end else begin : g_nosat
         assign sum_sat = sum_vec[MAX_TAPS-1];
      end
   endgenerate

   // Result register.
   always_comb begin
      if (out_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_count_ff  <= '0;
         load_index_ff <= '0;
         tails_ff      <= '0;
         last_ff       <= 1'b0;
         launch_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_count_ff  <= tap_count_in;
         load_index_ff <= load_index_in;
         tails_ff      <= tails_in;
         last_ff       <= last_in;
         launch_ff     <= shift;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_fire) begin
         rsp_data_ff.sum       <= sum_sat;
         rsp_data_ff.final_res <= last_ff && (tails_ff == '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Cell chain: samples shift right, the running sum walks one cell per cycle.
   generate
      for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
         flconv_cell_ctrl_type      ctrl;
         logic signed [VALUE_W-1:0] smp_prev;
         logic                      go_prev;
         logic signed [ACC_W-1:0]   sum_prev;

         assign ctrl.shift  = shift;
         assign ctrl.clear  = clear;
         assign ctrl.tap_we = load_fire && (load_index_ff == CNT_W'(j));
         assign ctrl.active = CNT_W'(j) < tap_count_ff;

         if (j == 0) begin : g_head
            assign smp_prev = shift_val;
            assign go_prev  = launch_ff;
            assign sum_prev = '0;
         end else begin : g_body
            assign smp_prev = smp_vec[j-1];
            assign go_prev  = go_vec[j-1];
            assign sum_prev = sum_vec[j-1];
         end

         flconv_cell #(
            .ACC_W(ACC_W)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .tap_in  (req_data.value),
            .smp_in  (smp_prev),
            .go_in   (go_prev),
            .sum_in  (sum_prev),
            .smp_out (smp_vec[j]),
            .go_out  (go_vec[j]),
            .sum_out (sum_vec[j])
         );
      end
   endgenerate

   // Only one running sum is ever in flight.
   a_single_wave: assert property (@(posedge clock) disable iff (reset)
      $onehot0({launch_ff, go_vec}))
      else $error("more than one running sum in the cell chain");

   // The chain end reports only while the sequencer waits for it.
   a_done_in_wave: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff == ST_WAVE))
      else $error("sum finished outside the wave state");

   // Tail outputs belong to a final sample only.
   a_tails_last: assert property (@(posedge clock) disable iff (reset)
      (tails_ff != '0) |-> last_ff)
      else $error("tail outputs pending without a final sample");

   // The last result of a request returns the block to idle.
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (out_fire && (tails_ff == '0)) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle");

   // The load index never runs past the tap store.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      load_index_ff <= CNT_W'(MAX_TAPS))
      else $error("load index beyond tap store");

endmodule
